[hdl/mwem_pkg.sv]
// ----------------------------------------------------------------------------
// mwem_pkg
// Shared types, codes and constants of the microwire EEPROM master.
// ----------------------------------------------------------------------------
package mwem_pkg;

  // default sizes, handed to the top level parameters
  localparam int MAX_ADDRESS_BITS_DEF = 10;
  localparam int WORD_BITS_DEF        = 16;

  // fixed field widths
  localparam int ADDR_W     = 10;
  localparam int DATA_W     = 16;
  localparam int MODE_W     = 3;
  localparam int CFG_AB_W   = 4;
  localparam int WAIT_W     = 16;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // command modes
  localparam logic [MODE_W-1:0] MODE_READ      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_WREN      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_WRDIS     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ_NEXT = 3'd4;

  // opcodes sent after the start bit
  localparam logic [1:0] OP_READ  = 2'b10;
  localparam logic [1:0] OP_WRITE = 2'b01;
  localparam logic [1:0] OP_CTRL  = 2'b00;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_ADDRESS_BITS = 2'd0;
  localparam logic [1:0] REG_PROGRAM_WAIT = 2'd1;
  localparam logic [1:0] REG_ENABLE_WAIT  = 2'd2;

  // register reset values
  localparam logic [CFG_AB_W-1:0] RST_ADDRESS_BITS = 4'd10;
  localparam logic [WAIT_W-1:0]   RST_PROGRAM_WAIT = 16'd25;
  localparam logic [WAIT_W-1:0]   RST_ENABLE_WAIT  = 16'd10;

  typedef struct packed {
    logic [CFG_AB_W-1:0] address_bits;
    logic [WAIT_W-1:0]   program_wait_slots;
    logic [WAIT_W-1:0]   enable_wait_slots;
  } cfg_t;

  typedef struct packed {
    logic              start_req;
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
    logic              keep_selected;
    logic              serial_in;
  } in_item_t;

  typedef struct packed {
    logic              chip_select;
    logic              serial_clock;
    logic              serial_out;
    logic              read_valid;
    logic [DATA_W-1:0] read_word;
    logic              busy_res;
  } res_t;

endpackage

[hdl/mwem_in_if.sv]
// ----------------------------------------------------------------------------
// mwem_in_if
// Slot request channel: valid/ready plus one serial bit slot request.
// ----------------------------------------------------------------------------
interface mwem_in_if;
  logic                        valid;
  logic                        ready;
  logic                        start_req;
  logic [mwem_pkg::MODE_W-1:0] mode;
  logic [mwem_pkg::ADDR_W-1:0] address;
  logic [mwem_pkg::DATA_W-1:0] write_data;
  logic                        keep_selected;
  logic                        serial_in;

  modport source (
    output valid, start_req, mode, address, write_data, keep_selected, serial_in,
    input  ready
  );

  modport sink (
    input  valid, start_req, mode, address, write_data, keep_selected, serial_in,
    output ready
  );
endinterface

[hdl/mwem_out_if.sv]
// ----------------------------------------------------------------------------
// mwem_out_if
// Slot result channel: valid/ready plus pin levels and read data.
// ----------------------------------------------------------------------------
interface mwem_out_if;
  logic                        valid;
  logic                        ready;
  logic                        chip_select;
  logic                        serial_clock;
  logic                        serial_out;
  logic                        read_valid;
  logic [mwem_pkg::DATA_W-1:0] read_word;
  logic                        busy_res;

  modport source (
    output valid, chip_select, serial_clock, serial_out, read_valid, read_word, busy_res,
    input  ready
  );

  modport sink (
    input  valid, chip_select, serial_clock, serial_out, read_valid, read_word, busy_res,
    output ready
  );
endinterface

[hdl/mwem_regs.sv]
// ----------------------------------------------------------------------------
// mwem_regs
// APB-style configuration registers: address bits and the two wait lengths.
// ----------------------------------------------------------------------------
module mwem_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mwem_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mwem_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mwem_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output mwem_pkg::cfg_t                  cfg
);
  import mwem_pkg::*;

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  // register write at the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.address_bits       <= RST_ADDRESS_BITS;
      cfg_r.program_wait_slots <= RST_PROGRAM_WAIT;
      cfg_r.enable_wait_slots  <= RST_ENABLE_WAIT;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_ADDRESS_BITS: cfg_r.address_bits       <= pwdata[CFG_AB_W-1:0];
        REG_PROGRAM_WAIT: cfg_r.program_wait_slots <= pwdata[WAIT_W-1:0];
        REG_ENABLE_WAIT:  cfg_r.enable_wait_slots  <= pwdata[WAIT_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (paddr[3:2])
      REG_ADDRESS_BITS: prdata = CFG_DATA_W'(cfg_r.address_bits);
      REG_PROGRAM_WAIT: prdata = CFG_DATA_W'(cfg_r.program_wait_slots);
      REG_ENABLE_WAIT:  prdata = CFG_DATA_W'(cfg_r.enable_wait_slots);
      default:          prdata = '0;
    endcase
  end

endmodule

[hdl/mwem_seq.sv]
// ----------------------------------------------------------------------------
// mwem_seq
// Slot sequencer: command framing, data shift, read sampling and waits.
// ----------------------------------------------------------------------------
module mwem_seq #(
  parameter int MAX_ADDRESS_BITS = mwem_pkg::MAX_ADDRESS_BITS_DEF,
  parameter int WORD_BITS        = mwem_pkg::WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  mwem_pkg::in_item_t item,
  input  mwem_pkg::cfg_t     cfg,
  output mwem_pkg::res_t     res
);
  import mwem_pkg::*;

  localparam int SHW = 3 + MAX_ADDRESS_BITS + WORD_BITS;
  localparam int BCW = $clog2(SHW + 1);
  localparam int ABW = $clog2(MAX_ADDRESS_BITS + 1);
  localparam int AXW = (MAX_ADDRESS_BITS > ADDR_W) ? MAX_ADDRESS_BITS : ADDR_W;

  typedef enum logic [7:0] {
    PH_IDLE      = 8'b0000_0001,
    PH_SEND      = 8'b0000_0010,
    PH_READ      = 8'b0000_0100,
    PH_CTRL_DROP = 8'b0000_1000,
    PH_SETTLE    = 8'b0001_0000,
    PH_WR_DROP   = 8'b0010_0000,
    PH_PROG      = 8'b0100_0000,
    PH_HELD      = 8'b1000_0000
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [BCW-1:0]       bit_count_r, bit_count_nxt;
  logic [SHW-1:0]       out_shift_r, out_shift_nxt;
  logic [WORD_BITS-1:0] in_shift_r, in_shift_nxt;
  logic [MODE_W-1:0]    latched_mode_r, latched_mode_nxt;
  logic                 held_select_r, held_select_nxt;
  logic [WAIT_W-1:0]    wait_count_r, wait_count_nxt;

  logic [ABW-1:0]              ab;
  logic [MAX_ADDRESS_BITS-1:0] amask;
  logic [AXW-1:0]              addr_ext;
  logic [MAX_ADDRESS_BITS-1:0] a_sel;
  logic [1:0]                  op;
  logic [SHW-1:0]              v_cmd;
  logic [BCW-1:0]              n_cmd;
  logic [SHW-1:0]              cmd_aligned;
  logic [BCW-1:0]              bc_dec;
  logic [WAIT_W-1:0]           wait_dec;
  logic [WORD_BITS-1:0]        in_cat;
  logic                        req_cmd;

  // command word for an accepted request, left aligned in the shifter
  always_comb begin
    if (cfg.address_bits > CFG_AB_W'(MAX_ADDRESS_BITS)) begin
      ab = ABW'(MAX_ADDRESS_BITS);
    end else begin
      ab = ABW'(cfg.address_bits);
    end
    amask    = MAX_ADDRESS_BITS'((32'd1 << ab) - 32'd1);
    addr_ext = AXW'(item.address);
    case (item.mode)
      MODE_READ: begin
        op    = OP_READ;
        a_sel = addr_ext[MAX_ADDRESS_BITS-1:0] & amask;
      end
      MODE_WRITE: begin
        op    = OP_WRITE;
        a_sel = addr_ext[MAX_ADDRESS_BITS-1:0] & amask;
      end
      MODE_WREN: begin
        op    = OP_CTRL;
        a_sel = amask;
      end
      default: begin
        op    = OP_CTRL;
        a_sel = '0;
      end
    endcase
    v_cmd = (SHW'({1'b1, op}) << ab) | SHW'(a_sel);
    n_cmd = BCW'(3) + BCW'(ab);
    if (item.mode == MODE_WRITE) begin
      v_cmd = (v_cmd << WORD_BITS) | SHW'(item.write_data[WORD_BITS-1:0]);
      n_cmd = n_cmd + BCW'(WORD_BITS);
    end
    cmd_aligned = v_cmd << (BCW'(SHW) - n_cmd);
  end

  // shared counter and shift helpers
  assign bc_dec   = (bit_count_r != '0) ? bit_count_r - BCW'(1) : '0;
  assign wait_dec = wait_count_r - WAIT_W'(1);
  assign in_cat   = {in_shift_r[WORD_BITS-2:0], item.serial_in};
  assign req_cmd  = item.start_req && (item.mode <= MODE_WRDIS);

  // next state and slot result
  always_comb begin
    phase_nxt        = phase_r;
    bit_count_nxt    = bit_count_r;
    out_shift_nxt    = out_shift_r;
    in_shift_nxt     = in_shift_r;
    latched_mode_nxt = latched_mode_r;
    held_select_nxt  = held_select_r;
    wait_count_nxt   = wait_count_r;
    res              = '0;

    unique case (phase_r)
      PH_IDLE: begin
        if (req_cmd) begin
          res.chip_select  = 1'b1;
          res.serial_clock = 1'b1;
          res.busy_res     = 1'b1;
          out_shift_nxt    = cmd_aligned;
          bit_count_nxt    = n_cmd;
          latched_mode_nxt = item.mode;
          held_select_nxt  = (item.mode == MODE_READ) && item.keep_selected;
          phase_nxt        = PH_SEND;
        end
      end
      PH_SEND: begin
        res.chip_select  = 1'b1;
        res.serial_clock = 1'b1;
        res.busy_res     = 1'b1;
        res.serial_out   = out_shift_r[SHW-1];
        out_shift_nxt    = out_shift_r << 1;
        bit_count_nxt    = bc_dec;
        if (bc_dec == '0) begin
          if (latched_mode_r == MODE_READ) begin
            phase_nxt     = PH_READ;
            bit_count_nxt = BCW'(WORD_BITS);
            in_shift_nxt  = '0;
          end else if (latched_mode_r == MODE_WRITE) begin
            phase_nxt = PH_WR_DROP;
          end else begin
            phase_nxt = PH_CTRL_DROP;
          end
        end
      end
      PH_READ: begin
        res.chip_select  = 1'b1;
        res.serial_clock = 1'b1;
        res.busy_res     = 1'b1;
        in_shift_nxt     = in_cat;
        bit_count_nxt    = bc_dec;
        if (bc_dec == '0) begin
          res.read_valid = 1'b1;
          res.read_word  = DATA_W'(in_cat);
          phase_nxt      = held_select_r ? PH_HELD : PH_IDLE;
        end
      end
      PH_CTRL_DROP: begin
        res.serial_clock = 1'b1;
        res.busy_res     = 1'b1;
        wait_count_nxt   = cfg.enable_wait_slots;
        phase_nxt        = (cfg.enable_wait_slots != '0) ? PH_SETTLE : PH_IDLE;
      end
      PH_SETTLE: begin
        res.busy_res   = 1'b1;
        wait_count_nxt = wait_dec;
        if (wait_dec == '0) begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_WR_DROP: begin
        res.busy_res   = 1'b1;
        wait_count_nxt = cfg.program_wait_slots;
        phase_nxt      = (cfg.program_wait_slots != '0) ? PH_PROG : PH_IDLE;
      end
      PH_PROG: begin
        res.chip_select = 1'b1;
        res.busy_res    = 1'b1;
        wait_count_nxt  = wait_dec;
        if (wait_dec == '0) begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_HELD: begin
        if (item.start_req && (item.mode == MODE_READ_NEXT)) begin
          // first sampled bit lands in the request slot
          res.chip_select  = 1'b1;
          res.serial_clock = 1'b1;
          res.busy_res     = 1'b1;
          latched_mode_nxt = MODE_READ_NEXT;
          held_select_nxt  = item.keep_selected;
          in_shift_nxt     = WORD_BITS'(item.serial_in);
          bit_count_nxt    = BCW'(WORD_BITS - 1);
          phase_nxt        = PH_READ;
        end else if (req_cmd) begin
          // another command ends the hold and is dropped
          held_select_nxt = 1'b0;
          phase_nxt       = PH_IDLE;
        end else begin
          res.chip_select = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // state registers, advanced once per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      bit_count_r    <= '0;
      latched_mode_r <= MODE_READ;
      held_select_r  <= 1'b0;
      wait_count_r   <= '0;
    end else if (fire) begin
      phase_r        <= phase_nxt;
      bit_count_r    <= bit_count_nxt;
      latched_mode_r <= latched_mode_nxt;
      held_select_r  <= held_select_nxt;
      wait_count_r   <= wait_count_nxt;
    end
  end

  // shift registers, no reset
  always_ff @(posedge clk) begin
    if (fire) begin
      out_shift_r <= out_shift_nxt;
      in_shift_r  <= in_shift_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // wait phases never sit on an expired count
  a_wait_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SETTLE || phase_r == PH_PROG) |-> (wait_count_r != '0))
    else $error("wait phase with zero count");

  // read phase always has bits left to sample
  a_read_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_READ) |-> (bit_count_r != '0))
    else $error("read phase with zero bit count");

  // a completed word leaves the read phase
  a_read_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.read_valid) |=> (phase_r == PH_IDLE || phase_r == PH_HELD))
    else $error("read did not finish after last bit");

  // only reads may hold chip select
  a_held_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HELD) |->
      (latched_mode_r == MODE_READ || latched_mode_r == MODE_READ_NEXT))
    else $error("hold entered from a non-read command");
`endif

endmodule

[hdl/mwem_out_buf.sv]
// ----------------------------------------------------------------------------
// mwem_out_buf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module mwem_out_buf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  mwem_pkg::res_t in_res,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output mwem_pkg::res_t out_res
);
  import mwem_pkg::*;

  logic out_valid_r;
  logic skid_valid_r;
  res_t out_res_r;
  res_t skid_res_r;
  logic pop;

  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign pop       = out_valid_r && out_ready;

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_valid) begin
      if (out_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end
      out_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_res_r <= skid_res_r;
      end
    end else if (in_valid) begin
      if (out_valid_r && !pop) begin
        skid_res_r <= in_res;
      end else begin
        out_res_r <= in_res;
      end
    end
  end

endmodule

[hdl/microwire_eeprom_master_core.sv]
// ----------------------------------------------------------------------------
// microwire_eeprom_master_core
// Microwire master for a word-organised serial EEPROM, one bit slot per transfer.
// ----------------------------------------------------------------------------
// a slot result is formed combinationally from its input transfer and registered in the result buffer
// throughput: one slot per cycle while the result buffer has room, set by the single-pass slot sequencer
// a two-entry result buffer keeps input transfers going for one stalled result
// reset: synchronous active-low rst_n; sequencer idle, registers at defaults
module microwire_eeprom_master_core #(
  parameter int MAX_ADDRESS_BITS = mwem_pkg::MAX_ADDRESS_BITS_DEF,
  parameter int WORD_BITS        = mwem_pkg::WORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mwem_in_if.sink                         in_ch,
  mwem_out_if.source                      out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [mwem_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [mwem_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [mwem_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import mwem_pkg::*;

  cfg_t     cfg;
  in_item_t item;
  res_t     slot_res;
  res_t     buf_res;
  logic     buf_ready;
  logic     fire;

  // input transfer
  assign item.start_req     = in_ch.start_req;
  assign item.mode          = in_ch.mode;
  assign item.address       = in_ch.address;
  assign item.write_data    = in_ch.write_data;
  assign item.keep_selected = in_ch.keep_selected;
  assign item.serial_in     = in_ch.serial_in;
  assign in_ch.ready        = buf_ready;
  assign fire               = in_ch.valid && buf_ready;

  mwem_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  mwem_seq #(
    .MAX_ADDRESS_BITS (MAX_ADDRESS_BITS),
    .WORD_BITS        (WORD_BITS)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item),
    .cfg   (cfg),
    .res   (slot_res)
  );

  mwem_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fire),
    .in_res    (slot_res),
    .in_ready  (buf_ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (buf_res)
  );

  // result transfer
  assign out_ch.chip_select  = buf_res.chip_select;
  assign out_ch.serial_clock = buf_res.serial_clock;
  assign out_ch.serial_out   = buf_res.serial_out;
  assign out_ch.read_valid   = buf_res.read_valid;
  assign out_ch.read_word    = buf_res.read_word;
  assign out_ch.busy_res     = buf_res.busy_res;

endmodule

[test/microwire_eeprom_master_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// microwire_eeprom_master_core_tb
// Self-checking bench for the microwire EEPROM master core. Bit slots are
// queued as complete read, write and enable/disable commands with random
// filler and noise. A slot sequencer model predicts the pin levels of every
// transfer, and the result channel is compared field by field. The bench
// steps through several register settings, including address widths 0 and
// 15 and program/settle waits from 0 up to a few tens of slots. Both
// channels stall at random.
// ----------------------------------------------------------------------------
module microwire_eeprom_master_core_tb;
  import mwem_pkg::*;

  localparam int WORD_BITS   = WORD_BITS_DEF;
  localparam int MAX_AB      = MAX_ADDRESS_BITS_DEF;
  localparam int LONG_HOLD   = 48;
  localparam int STALL_LIMIT = 2000;

  // spare mode codes the sequencer has to ignore
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_SEND, SQ_READ, SQ_CTRL_DROP, SQ_SETTLE, SQ_WR_DROP, SQ_PROG, SQ_HELD
  } sq_phase_e;

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  mwem_in_if  in_ch ();
  mwem_out_if out_ch ();

  microwire_eeprom_master_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // slot sequencer model state and register copy
  sq_phase_e         sq_phase;
  logic [4:0]        sq_bits_left;
  logic [31:0]       sq_tx_shift;
  logic [DATA_W-1:0] sq_rx_shift;
  logic [MODE_W-1:0] sq_mode;
  logic              sq_hold;
  logic [WAIT_W-1:0] sq_wait;
  cfg_t              cfg_mirror;

  in_item_t slot_q[$];      // slots waiting to be driven
  res_t     pins_due_q[$];  // predicted pin levels, oldest first
  in_item_t next_slot;
  in_item_t seen_slot;
  res_t     want;

  // generator view of the block
  int gen_ab;
  int gen_pw;
  int gen_ew;
  bit gen_held;

  bit calm = 1'b0;
  bit long_hold_pending = 1'b0;
  int src_gap = 0;
  int snk_gap = 0;
  int fail_count = 0;
  int slots_seen = 0;
  int words_read = 0;
  int gen_cmds = 0;
  int settings_run = 1;
  int idle_cycles;

  // ---------------------------------------------------------------------------
  // model of one bit slot
  // ---------------------------------------------------------------------------

  // shift one device bit in; flags the word when the last bit lands
  function automatic void shift_in_bit(input logic sin, inout res_t r);
    sq_rx_shift = {sq_rx_shift[DATA_W-2:0], sin};
    if (sq_bits_left != 0) sq_bits_left = sq_bits_left - 5'd1;
    if (sq_bits_left == 0) begin
      r.read_valid = 1'b1;
      r.read_word  = sq_rx_shift;
      if (sq_hold) sq_phase = SQ_HELD;
      else sq_phase = SQ_IDLE;
    end
  endfunction

  // build the serial frame: start bit, opcode, address, then data for writes
  function automatic void load_command(in_item_t it);
    int          ab;
    int          amask;
    int          a;
    int          n;
    logic [1:0]  op;
    logic [31:0] v;
    ab = (int'(cfg_mirror.address_bits) > MAX_AB) ? MAX_AB : int'(cfg_mirror.address_bits);
    amask = (1 << ab) - 1;
    case (it.mode)
      MODE_READ: begin
        op = OP_READ;
        a  = int'(it.address) & amask;
      end
      MODE_WRITE: begin
        op = OP_WRITE;
        a  = int'(it.address) & amask;
      end
      MODE_WREN: begin
        op = OP_CTRL;
        a  = amask;
      end
      default: begin
        op = OP_CTRL;
        a  = 0;
      end
    endcase
    v = {29'd0, 1'b1, op};
    v = (v << ab) | a;
    n = 3 + ab;
    if (it.mode == MODE_WRITE) begin
      v = (v << WORD_BITS) | 32'(it.write_data);
      n = n + WORD_BITS;
    end
    sq_tx_shift  = v << (32 - n);
    sq_bits_left = 5'(n);
    sq_mode      = it.mode;
    sq_hold      = (it.mode == MODE_READ) ? it.keep_selected : 1'b0;
    sq_phase     = SQ_SEND;
  endfunction

  function automatic res_t sequence_slot(in_item_t it);
    res_t r;
    r = '0;
    case (sq_phase)
      SQ_IDLE: begin
        if (it.start_req && it.mode <= MODE_WRDIS) begin
          load_command(it);
          r.chip_select  = 1'b1;
          r.serial_clock = 1'b1;
          r.busy_res     = 1'b1;
        end
      end
      SQ_SEND: begin
        r.chip_select  = 1'b1;
        r.serial_clock = 1'b1;
        r.busy_res     = 1'b1;
        r.serial_out   = sq_tx_shift[31];
        sq_tx_shift    = sq_tx_shift << 1;
        if (sq_bits_left != 0) sq_bits_left = sq_bits_left - 5'd1;
        if (sq_bits_left == 0) begin
          if (sq_mode == MODE_READ) begin
            sq_phase     = SQ_READ;
            sq_bits_left = 5'(WORD_BITS);
            sq_rx_shift  = '0;
          end else if (sq_mode == MODE_WRITE) begin
            sq_phase = SQ_WR_DROP;
          end else begin
            sq_phase = SQ_CTRL_DROP;
          end
        end
      end
      SQ_READ: begin
        r.chip_select  = 1'b1;
        r.serial_clock = 1'b1;
        r.busy_res     = 1'b1;
        shift_in_bit(it.serial_in, r);
      end
      SQ_CTRL_DROP: begin
        r.serial_clock = 1'b1;
        r.busy_res     = 1'b1;
        sq_wait        = cfg_mirror.enable_wait_slots;
        if (sq_wait != 0) sq_phase = SQ_SETTLE;
        else sq_phase = SQ_IDLE;
      end
      SQ_SETTLE: begin
        r.busy_res = 1'b1;
        sq_wait    = sq_wait - WAIT_W'(1);
        if (sq_wait == 0) sq_phase = SQ_IDLE;
      end
      SQ_WR_DROP: begin
        r.busy_res = 1'b1;
        sq_wait    = cfg_mirror.program_wait_slots;
        if (sq_wait != 0) sq_phase = SQ_PROG;
        else sq_phase = SQ_IDLE;
      end
      SQ_PROG: begin
        r.chip_select = 1'b1;
        r.busy_res    = 1'b1;
        sq_wait       = sq_wait - WAIT_W'(1);
        if (sq_wait == 0) sq_phase = SQ_IDLE;
      end
      SQ_HELD: begin
        if (it.start_req && it.mode == MODE_READ_NEXT) begin
          r.chip_select  = 1'b1;
          r.serial_clock = 1'b1;
          r.busy_res     = 1'b1;
          sq_mode        = MODE_READ_NEXT;
          sq_hold        = it.keep_selected;
          sq_rx_shift    = '0;
          sq_bits_left   = 5'(WORD_BITS);
          sq_phase       = SQ_READ;
          shift_in_bit(it.serial_in, r);
        end else if (it.start_req && it.mode <= MODE_WRDIS) begin
          // any other command only releases select
          sq_hold  = 1'b0;
          sq_phase = SQ_IDLE;
        end else begin
          r.chip_select = 1'b1;
        end
      end
      default: sq_phase = SQ_IDLE;
    endcase
    return r;
  endfunction

  // predict on every accepted input transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      sq_phase     = SQ_IDLE;
      sq_bits_left = '0;
      sq_tx_shift  = '0;
      sq_rx_shift  = '0;
      sq_mode      = '0;
      sq_hold      = 1'b0;
      sq_wait      = '0;
      cfg_mirror   = {RST_ADDRESS_BITS, RST_PROGRAM_WAIT, RST_ENABLE_WAIT};
      pins_due_q.delete();
    end else if (in_ch.valid && in_ch.ready) begin
      seen_slot = {in_ch.start_req, in_ch.mode, in_ch.address, in_ch.write_data,
                   in_ch.keep_selected, in_ch.serial_in};
      pins_due_q.push_back(sequence_slot(seen_slot));
    end
  end

  // ---------------------------------------------------------------------------
  // driver: one slot per transfer, random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (src_gap > 0) begin
        src_gap--;
        in_ch.valid <= 1'b0;
      end else if (slot_q.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 8) begin
        src_gap = $urandom_range(0, 5);
        in_ch.valid <= 1'b0;
      end else begin
        next_slot = slot_q.pop_front();
        in_ch.start_req     <= next_slot.start_req;
        in_ch.mode          <= next_slot.mode;
        in_ch.address       <= next_slot.address;
        in_ch.write_data    <= next_slot.write_data;
        in_ch.keep_selected <= next_slot.keep_selected;
        in_ch.serial_in     <= next_slot.serial_in;
        in_ch.valid         <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compare result transfers, drive ready with stalls
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        slots_seen++;
        if (pins_due_q.size() == 0) begin
          fail_count++;
          $display("%0t: result transfer with nothing expected", $time);
        end else begin
          want = pins_due_q.pop_front();
          check_field("chip_select", 32'(want.chip_select), 32'(out_ch.chip_select));
          check_field("serial_clock", 32'(want.serial_clock), 32'(out_ch.serial_clock));
          check_field("serial_out", 32'(want.serial_out), 32'(out_ch.serial_out));
          check_field("read_valid", 32'(want.read_valid), 32'(out_ch.read_valid));
          check_field("read_word", 32'(want.read_word), 32'(out_ch.read_word));
          check_field("busy_res", 32'(want.busy_res), 32'(out_ch.busy_res));
          if (want.read_valid) words_read++;
        end
      end
      // receiver stalls: one long hold on request, short random bursts otherwise
      if (snk_gap > 0) begin
        snk_gap--;
        out_ch.ready <= 1'b0;
      end else if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        snk_gap = LONG_HOLD - 1;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 8) begin
        snk_gap = $urandom_range(0, 5);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transfer at all
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || cfg_psel || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("microwire_eeprom_master_core verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------
  function automatic in_item_t rand_slot();
    in_item_t it;
    it.start_req     = 1'($urandom_range(0, 1));
    it.mode          = MODE_W'($urandom_range(0, 7));
    it.address       = ADDR_W'($urandom_range(0, 1023));
    it.write_data    = DATA_W'($urandom_range(0, 65535));
    it.keep_selected = 1'($urandom_range(0, 1));
    it.serial_in     = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic in_item_t req_slot(logic req, logic [MODE_W-1:0] m, logic keep);
    in_item_t it;
    it = rand_slot();
    it.start_req     = req;
    it.mode          = m;
    it.keep_selected = keep;
    return it;
  endfunction

  // random filler while the sequencer is busy; requests in it are ignored
  task automatic push_busy(int n);
    repeat (n) slot_q.push_back(rand_slot());
  endtask

  // the slots of one read word, device bits MSB first; head is the first slot
  task automatic push_read_word(in_item_t head, logic [DATA_W-1:0] dev_word);
    in_item_t it;
    for (int i = DATA_W - 1; i >= 0; i--) begin
      it = (i == DATA_W - 1) ? head : rand_slot();
      it.serial_in = dev_word[i];
      slot_q.push_back(it);
    end
  endtask

  task automatic push_read_next(logic keep, logic [DATA_W-1:0] dev_word);
    push_read_word(req_slot(1'b1, MODE_READ_NEXT, keep), dev_word);
    gen_held = keep;
  endtask

  // a full command; while select is held the first request only releases it
  task automatic push_cmd(logic [MODE_W-1:0] m, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d,
                          logic keep, logic [DATA_W-1:0] dev_word);
    in_item_t it;
    if (gen_held) slot_q.push_back(req_slot(1'b1, m, keep));
    gen_held = 1'b0;
    it = req_slot(1'b1, m, keep);
    it.address    = a;
    it.write_data = d;
    slot_q.push_back(it);
    gen_cmds++;
    case (m)
      MODE_READ: begin
        push_busy(3 + gen_ab);
        push_read_word(rand_slot(), dev_word);
        gen_held = keep;
      end
      MODE_WRITE: push_busy(3 + gen_ab + DATA_W + 1 + gen_pw);
      default:    push_busy(3 + gen_ab + 1 + gen_ew);
    endcase
  endtask

  // mostly well-formed commands, some quiet and ignored slots
  task automatic push_random_op();
    int       pick;
    in_item_t it;
    pick = $urandom_range(0, 99);
    if (gen_held && pick < 55) begin
      push_read_next($urandom_range(0, 99) < 50, DATA_W'($urandom));
    end else if (gen_held && pick < 75) begin
      it = req_slot(1'b0, MODE_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 1)) begin
        it.start_req = 1'b1;
        it.mode      = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      end
      slot_q.push_back(it);
    end else if (!gen_held && pick < 8) begin
      it = req_slot(1'b0, MODE_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 1)) begin
        it.start_req = 1'b1;
        it.mode      = MODE_W'($urandom_range(MODE_READ_NEXT, MODE_SPARE_HI));
      end
      slot_q.push_back(it);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 45)
        push_cmd(MODE_READ, ADDR_W'($urandom), DATA_W'($urandom),
                 $urandom_range(0, 99) < 40, DATA_W'($urandom));
      else if (pick < 75)
        push_cmd(MODE_WRITE, ADDR_W'($urandom), DATA_W'($urandom),
                 1'($urandom_range(0, 1)), DATA_W'($urandom));
      else if (pick < 88)
        push_cmd(MODE_WREN, ADDR_W'($urandom), DATA_W'($urandom),
                 1'($urandom_range(0, 1)), DATA_W'($urandom));
      else
        push_cmd(MODE_WRDIS, ADDR_W'($urandom), DATA_W'($urandom),
                 1'($urandom_range(0, 1)), DATA_W'($urandom));
    end
  endtask

  task automatic push_random_ops(int n_slots);
    int stop_at;
    stop_at = slot_q.size() + n_slots;
    while (slot_q.size() < stop_at) push_random_op();
  endtask

  // wait until every queued slot has gone through and its result is back
  task automatic drain();
    do @(negedge clk); while (slot_q.size() != 0 || in_ch.valid || pins_due_q.size() != 0);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_ADDRESS_BITS: cfg_mirror.address_bits       = value[CFG_AB_W-1:0];
      REG_PROGRAM_WAIT: cfg_mirror.program_wait_slots = value[WAIT_W-1:0];
      REG_ENABLE_WAIT:  cfg_mirror.enable_wait_slots  = value[WAIT_W-1:0];
      default: ;
    endcase
  endtask

  // new register setting once the block has gone quiet
  task automatic apply_setting(int ab, int pw, int ew);
    drain();
    repeat (3) @(posedge clk);
    write_reg(REG_ADDRESS_BITS, ab);
    write_reg(REG_PROGRAM_WAIT, pw);
    write_reg(REG_ENABLE_WAIT, ew);
    gen_ab = ((ab & 15) > MAX_AB) ? MAX_AB : (ab & 15);
    gen_pw = pw & 16'hFFFF;
    gen_ew = ew & 16'hFFFF;
    gen_held = (sq_phase == SQ_HELD);
    settings_run++;
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.start_req     = 1'b0;
    in_ch.mode          = MODE_READ;
    in_ch.address       = '0;
    in_ch.write_data    = '0;
    in_ch.keep_selected = 1'b0;
    in_ch.serial_in     = 1'b0;
    out_ch.ready        = 1'b0;
    cfg_psel            = 1'b0;
    cfg_penable         = 1'b0;
    cfg_pwrite          = 1'b0;
    cfg_paddr           = '0;
    cfg_pwdata          = '0;
    gen_ab   = int'(RST_ADDRESS_BITS);
    gen_pw   = int'(RST_PROGRAM_WAIT);
    gen_ew   = int'(RST_ENABLE_WAIT);
    gen_held = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed pass at the reset register values
    slot_q.push_back(req_slot(1'b1, MODE_READ_NEXT, 1'b0));  // read next while idle
    slot_q.push_back(req_slot(1'b1, MODE_SPARE_HI, 1'b1));   // spare mode while idle
    slot_q.push_back(req_slot(1'b0, MODE_READ, 1'b0));
    push_cmd(MODE_READ, 10'h000, 16'h0000, 1'b0, 16'hFFFF);
    push_cmd(MODE_READ, 10'h3FF, 16'hFFFF, 1'b1, 16'h0000);
    slot_q.push_back(req_slot(1'b0, MODE_READ, 1'b1));       // held, no request
    slot_q.push_back(req_slot(1'b1, MODE_SPARE_LO, 1'b0));   // held, spare mode
    push_read_next(1'b1, 16'h8000);
    push_read_next(1'b0, 16'h0001);
    push_cmd(MODE_WRITE, 10'h3FF, 16'hFFFF, 1'b0, 16'h0000);
    push_cmd(MODE_WRITE, 10'h000, 16'h0000, 1'b1, 16'h0000);
    push_cmd(MODE_WREN, 10'h000, 16'h0000, 1'b0, 16'h0000);
    push_cmd(MODE_WRDIS, 10'h3FF, 16'hFFFF, 1'b1, 16'h0000);
    push_cmd(MODE_READ, 10'h2AA, 16'h0000, 1'b1, 16'h5555);
    push_cmd(MODE_WRITE, 10'h155, 16'hA5A5, 1'b0, 16'h0000);  // first request drops the hold

    // six-bit address and no waits, with one long receiver hold
    apply_setting(6, 0, 0);
    push_random_ops(70);
    long_hold_pending = 1'b1;

    apply_setting(10, 1, 1);
    push_random_ops(70);

    // address widths outside the device range: none sent, and clamped
    apply_setting(0, 2, 3);
    push_random_ops(45);
    apply_setting(15, 4, 0);
    push_random_ops(45);

    // longer programming and settle waits, one write, one enable and one read
    apply_setting(8, 30, 20);
    push_cmd(MODE_WRITE, ADDR_W'($urandom), DATA_W'($urandom), 1'b0, 16'h0000);
    push_cmd(MODE_WREN, ADDR_W'($urandom), DATA_W'($urandom), 1'b0, 16'h0000);
    push_cmd(MODE_READ, ADDR_W'($urandom), DATA_W'($urandom), 1'b0, DATA_W'($urandom));

    for (int p = 0; p < 3; p++) begin
      apply_setting($urandom_range(6, 10), $urandom_range(0, 30), $urandom_range(0, 30));
      if (p == 2) calm = 1'b1;
      push_random_ops(25);
    end

    drain();
    repeat (5) @(posedge clk);
    if (pins_due_q.size() != 0) begin
      fail_count++;
      $display("%0t: %0d results never arrived", $time, pins_due_q.size());
    end

    $display("covered %0d slot transfers, %0d read words, %0d commands", slots_seen,
             words_read, gen_cmds);
    $display("over %0d register settings incl. address widths 0/15 and waits 0 to 30",
             settings_run);
    if (fail_count == 0)
      $display("microwire_eeprom_master_core verification clean");
    else
      $display("microwire_eeprom_master_core verification failed");
    $finish;
  end

endmodule
